### rtl/core/rrv_pkg.sv
// ----------------------------------------------------------------------------
// rrv_pkg: shared types and constants of the refraction vector pipeline
// Transfer structs for both channels and fixed-point format constants.
// ----------------------------------------------------------------------------
package rrv_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int ROOT_BITS  = 25;             // floor sqrt of cos2 fits here
  localparam int RAD_BITS   = 2 * ROOT_BITS;  // cos2 radicand width
  localparam int DEPTH_DEF  = ROOT_BITS;      // one root digit per stage

  // Bits of culling_mode; the enter bit has priority.
  localparam int MODE_ENTER_BIT = 0;
  localparam int MODE_LEAVE_BIT = 1;

  localparam logic signed [15:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [15:0] OUT_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [15:0] incident_x;
    logic signed [15:0] incident_y;
    logic signed [15:0] incident_z;
    logic signed [15:0] incident_w;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] normal_w;
    logic [15:0]        eta_enter;
    logic [15:0]        eta_leave;
    logic [1:0]         culling_mode;
  } rrv_in_t;

  typedef struct packed {
    logic signed [15:0] refracted_x;
    logic signed [15:0] refracted_y;
    logic signed [15:0] refracted_z;
    logic signed [15:0] refracted_w;
    logic               total_reflection;
  } rrv_out_t;

  // Per-ray context that rides along the pipeline.
  typedef struct packed {
    logic [3:0][15:0] inc;  // incident lanes, signed s3.12
    logic [3:0][16:0] nrm;  // normal lanes after side selection, signed
    logic [15:0]      eta;  // chosen ratio, u4.12
    logic [25:0]      en;   // eta * dot rounded, signed Q12
    logic             tir;  // total internal reflection
  } rrv_ctx_t;

endpackage

### rtl/core/ray_refraction_vector.sv
// ----------------------------------------------------------------------------
// ray_refraction_vector: Snell refraction of a direction vector, fixed point
// Deeply pipelined; one ray per cycle while responses are taken, with a digit-per-stage square root.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_ready, req) carries one ray hit:
//   incident and normal vectors in s3.12, two u4.12 index ratios and a
//   culling mode. The response channel (rsp_valid, rsp_ready, rsp) returns
//   the refracted vector in s3.12, saturated, plus a total reflection flag.
//   Every request transfer produces exactly one response transfer, in order.
//   The pipeline has 6 + ROOT_STEPS + 3 register stages; a response becomes
//   valid when its request reaches the last of them. The square root
//   resolves one result bit per pipeline stage (default of 25 root steps)
//   and sets that depth.
//   Throughput is one ray per cycle while the receiver takes responses.
//   When the receiver stalls with a response waiting, the whole pipeline
//   holds in place and req_ready drops in the same cycle; nothing is lost
//   or repeated. Bubbles inside the pipeline travel with cleared valid bits.
//   Reset clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
module ray_refraction_vector #(
  parameter int ROOT_STEPS = rrv_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  rrv_pkg::rrv_in_t req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rrv_pkg::rrv_out_t rsp
);
  import rrv_pkg::*;

  localparam int RW = 2 * ROOT_STEPS;    // radicand width
  localparam int NST = 6 + ROOT_STEPS + 3;

  // Global advance: the pipeline moves when the output slot is free or taken.
  logic adv;
  logic [NST-1:0] vld;

  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv;
  assign rsp_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], req_valid};
    end
  end

  // Stage 1: lane products and input capture.
  rrv_ctx_t c1;
  logic [15:0] eta_a1, eta_b1;
  logic [1:0]  mode1;
  logic signed [31:0] p1 [4];
  logic [3:0][15:0] in_inc, in_nrm;

  assign in_inc = {req.incident_x, req.incident_y, req.incident_z, req.incident_w};
  assign in_nrm = {req.normal_x, req.normal_y, req.normal_z, req.normal_w};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        c1.inc[i] <= in_inc[i];
        c1.nrm[i] <= {in_nrm[i][15], in_nrm[i]};
        p1[i]     <= 32'($signed(in_inc[i])) * 32'($signed(in_nrm[i]));
      end
      c1.eta <= '0;
      c1.en  <= '0;
      c1.tir <= 1'b0;
      eta_a1 <= req.eta_enter;
      eta_b1 <= req.eta_leave;
      mode1  <= req.culling_mode;
    end
  end

  // Stage 2: dot product, side selection, normal negation.
  logic signed [33:0] dot2, d2;
  logic entering2;
  rrv_ctx_t c2, c2_next;

  always_comb begin
    dot2 = 34'(p1[0]) + 34'(p1[1]) + 34'(p1[2]) + 34'(p1[3]);
    entering2 = mode1[MODE_ENTER_BIT] || (!mode1[MODE_LEAVE_BIT] && dot2[33]);
    c2_next = c1;
    c2_next.eta = entering2 ? eta_a1 : eta_b1;
    for (int i = 0; i < 4; i++) begin
      c2_next.nrm[i] = entering2 ? c1.nrm[i] : 17'(-$signed(c1.nrm[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2 <= c2_next;
      d2 <= entering2 ? dot2 : -dot2;
    end
  end

  // Stage 3: eta * dot.
  rrv_ctx_t c3;
  logic signed [50:0] m3;
  always_ff @(posedge clk) begin
    if (adv) begin
      c3 <= c2;
      m3 <= 51'($signed({1'b0, c2.eta})) * 51'(d2);
    end
  end

  // Stage 4: round eta * dot to Q12.
  rrv_ctx_t c4, c4_next;
  logic signed [51:0] m3r;
  assign m3r = 52'(m3) + 52'(1 <<< 23);
  always_comb begin
    c4_next    = c3;
    c4_next.en = 26'(m3r >>> 24);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c4 <= c4_next;
    end
  end

  // Stage 5: squares.
  rrv_ctx_t c5;
  logic [31:0] ee5;
  logic [48:0] nn5;
  logic signed [51:0] nn_full;
  assign nn_full = 52'($signed(c4.en)) * 52'($signed(c4.en));
  always_ff @(posedge clk) begin
    if (adv) begin
      c5  <= c4;
      ee5 <= 32'(c4.eta) * 32'(c4.eta);
      nn5 <= nn_full[48:0];
    end
  end

  // Stage 6: cos2 and the total reflection decision. The result is loaded
  // straight into the first slot of the root pipeline.
  rrv_ctx_t c6_next;
  logic signed [50:0] cos6;
  assign cos6 = 51'(1 <<< 24) - 51'(ee5) + 51'(nn5);
  always_comb begin
    c6_next     = c5;
    c6_next.tir = cos6[50];
  end

  // Square root: one result bit per stage, restoring method.
  rrv_ctx_t          sq_c    [ROOT_STEPS+1];
  logic [RW-1:0]     sq_rad  [ROOT_STEPS+1];
  logic [ROOT_STEPS+1:0] sq_rem  [ROOT_STEPS+1];
  logic [ROOT_STEPS-1:0] sq_root [ROOT_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_c[0]    <= c6_next;
      sq_rad[0]  <= cos6[50] ? '0 : RW'(cos6);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    logic [ROOT_STEPS+3:0] t, trial;
    logic take;
    assign t     = {sq_rem[j], sq_rad[j][RW-1 -: 2]};
    assign trial = {2'b00, sq_root[j], 2'b01};
    assign take  = t >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_c[j+1]    <= sq_c[j];
        sq_rad[j+1]  <= {sq_rad[j][RW-3:0], 2'b00};
        sq_rem[j+1]  <= take ? (ROOT_STEPS+2)'(t - trial) : (ROOT_STEPS+2)'(t);
        sq_root[j+1] <= {sq_root[j][ROOT_STEPS-2:0], take};
      end
    end
  end

  // k = en + sqrt(cos2).
  rrv_ctx_t ck;
  logic signed [ROOT_STEPS+1:0] kk;
  always_ff @(posedge clk) begin
    if (adv) begin
      ck <= sq_c[ROOT_STEPS];
      kk <= (ROOT_STEPS+2)'($signed(sq_c[ROOT_STEPS].en))
          + $signed({2'b00, sq_root[ROOT_STEPS]});
    end
  end

  // Lane products.
  logic cp_tir;
  logic signed [32:0] pa [4];
  logic signed [ROOT_STEPS+18:0] pb [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      cp_tir <= ck.tir;
      for (int i = 0; i < 4; i++) begin
        pa[i] <= 33'($signed({1'b0, ck.eta})) * 33'($signed(ck.inc[i]));
        pb[i] <= (ROOT_STEPS+19)'(kk) * (ROOT_STEPS+19)'($signed(ck.nrm[i]));
      end
    end
  end

  // Difference, rounding, saturation, output register.
  logic [3:0][15:0] lane_o;
  always_comb begin
    logic signed [ROOT_STEPS+20:0] dd;
    logic signed [ROOT_STEPS+20:0] q;
    for (int i = 0; i < 4; i++) begin
      dd = (ROOT_STEPS+21)'(pa[i]) - (ROOT_STEPS+21)'(pb[i])
         + (ROOT_STEPS+21)'(1 <<< (FRAC_BITS-1));
      q  = dd >>> FRAC_BITS;
      if (cp_tir) begin
        lane_o[i] = '0;
      end else if (q > (ROOT_STEPS+21)'(OUT_MAX)) begin
        lane_o[i] = OUT_MAX;
      end else if (q < (ROOT_STEPS+21)'(OUT_MIN)) begin
        lane_o[i] = OUT_MIN;
      end else begin
        lane_o[i] = q[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.refracted_x      <= lane_o[3];
      rsp.refracted_y      <= lane_o[2];
      rsp.refracted_z      <= lane_o[1];
      rsp.refracted_w      <= lane_o[0];
      rsp.total_reflection <= cp_tir;
    end
  end

`ifndef SYNTH
  // A total reflection result is always the zero vector.
  a_tir_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.total_reflection |->
      rsp.refracted_x == 0 && rsp.refracted_y == 0 &&
      rsp.refracted_z == 0 && rsp.refracted_w == 0)
    else $error("total reflection with nonzero vector");

  // Backpressure appears only when a response is held by the receiver.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request side stalled without a held response");

  // A stalled pipeline keeps its valid pattern.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("valid bits moved during a stall");
`endif

endmodule
